@@ design/sstv_pkg.sv @@
package sstv_pkg;

  // Default sizes of the storage and phase datapath.
  localparam int unsigned LinePixelsDef  = 1024;
  localparam int unsigned SineEntriesDef = 1024;
  localparam int unsigned PhaseBitsDef   = 32;

  // Field widths.
  localparam int unsigned OpW      = 2;
  localparam int unsigned PixIdxW  = 10;
  localparam int unsigned PixValW  = 8;
  localparam int unsigned Freq16W  = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned LineWidW = 11;
  localparam int unsigned RateW    = 18;
  localparam int unsigned AmpW     = 15;
  localparam int unsigned CapW     = 25;
  localparam int unsigned CntW     = 25;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 25;
  localparam int unsigned MagW     = 15;

  // Microseconds per second and the width of that constant.
  localparam int unsigned UsPerSW = 20;
  localparam logic [UsPerSW-1:0] UsPerS = 20'd1000000;

  // Register reset values.
  localparam logic [RateW-1:0] RateRst  = 18'd44100;
  localparam logic [AmpW-1:0]  AmpRst   = 15'd32767;
  localparam logic [15:0]      BlackRst = 16'd24000;
  localparam logic [15:0]      StepRst  = 16'd12850;
  localparam logic [CapW-1:0]  CapRst   = 25'd16777216;

  typedef enum logic [OpW-1:0] {
    OP_LOAD    = 2'd0,
    OP_TONE    = 2'd1,
    OP_SCAN    = 2'd2,
    OP_RESTART = 2'd3
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    ST_SAMPLE = 2'd0,
    ST_DONE   = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RATE  = 3'd0,
    CFG_AMP   = 3'd1,
    CFG_BLACK = 3'd2,
    CFG_STEP  = 3'd3,
    CFG_CAP   = 3'd4
  } cfg_reg_e;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_LOAD,
    CMD_RESTART,
    CMD_MUL_A,
    CMD_MUL_B,
    CMD_CHECK,
    CMD_NW,
    CMD_PDIV_LD,
    CMD_SDIV_LD,
    CMD_DIV_STEP,
    CMD_PIX,
    CMD_READ,
    CMD_FREQ,
    CMD_EMIT
  } dp_cmd_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MUL_A,
    S_MUL_B,
    S_CHECK,
    S_NW,
    S_PDIV_LD,
    S_PDIV,
    S_PIX,
    S_READ,
    S_FREQ,
    S_SDIV_LD,
    S_SDIV,
    S_EMIT
  } ctrl_state_e;

  // Status from the datapath back to the controller.
  typedef struct packed {
    opcode_e op;
    logic    stop;
    logic    div_done;
    logic    out_busy;
  } dp_status_t;

  // Quarter-wave sine magnitude in Q15 for table entry num of 2^qlog entries.
  // Only evaluated at elaboration to build the constant table.
  function automatic logic [MagW-1:0] sine_mag(input int unsigned num,
                                               input int unsigned qlog);
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] t;
    logic [63:0] m;
    u  = (64'(num) << 30) >> qlog;
    u2 = (u * u) >> 30;
    t  = 64'd5026994 - ((u2 * 64'd172273) >> 30);
    t  = 64'd85569306 - ((u2 * t) >> 30);
    t  = 64'd693598668 - ((u2 * t) >> 30);
    t  = 64'd1686629713 - ((u2 * t) >> 30);
    m  = (((u * t) >> 30) + 64'd16384) >> 15;
    if (m > 64'd32767) begin
      m = 64'd32767;
    end
    return MagW'(m);
  endfunction

endpackage

@@ design/sstv_ctrl.sv @@
module sstv_ctrl
  import sstv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output dp_cmd_e    cmd_o
);

  ctrl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath command.
  always_comb begin
    state_d    = state_q;
    cmd_o      = CMD_NONE;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o   = CMD_LATCH;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (status_i.op)
          OP_LOAD: begin
            cmd_o   = CMD_LOAD;
            state_d = S_IDLE;
          end
          OP_RESTART: begin
            cmd_o   = CMD_RESTART;
            state_d = S_IDLE;
          end
          default: begin
            cmd_o   = CMD_MUL_A;
            state_d = S_MUL_B;
          end
        endcase
      end
      S_MUL_A: begin
        cmd_o   = CMD_MUL_A;
        state_d = S_MUL_B;
      end
      S_MUL_B: begin
        cmd_o   = CMD_MUL_B;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        cmd_o = CMD_CHECK;
        priority if (status_i.stop) begin
          state_d = S_EMIT;
        end else if (status_i.op == OP_TONE) begin
          state_d = S_SDIV_LD;
        end else begin
          state_d = S_NW;
        end
      end
      S_NW: begin
        cmd_o   = CMD_NW;
        state_d = S_PDIV_LD;
      end
      S_PDIV_LD: begin
        cmd_o   = CMD_PDIV_LD;
        state_d = S_PDIV;
      end
      S_PDIV: begin
        if (status_i.div_done) begin
          state_d = S_PIX;
        end else begin
          cmd_o = CMD_DIV_STEP;
        end
      end
      S_PIX: begin
        cmd_o   = CMD_PIX;
        state_d = S_READ;
      end
      S_READ: begin
        cmd_o   = CMD_READ;
        state_d = S_FREQ;
      end
      S_FREQ: begin
        cmd_o   = CMD_FREQ;
        state_d = S_SDIV_LD;
      end
      S_SDIV_LD: begin
        cmd_o   = CMD_SDIV_LD;
        state_d = S_SDIV;
      end
      S_SDIV: begin
        if (status_i.div_done) begin
          state_d = S_EMIT;
        end else begin
          cmd_o = CMD_DIV_STEP;
        end
      end
      S_EMIT: begin
        // Hold until the output register is free or being emptied.
        if (!status_i.out_busy) begin
          cmd_o   = CMD_EMIT;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

@@ design/sstv_dp.sv @@
module sstv_dp
  import sstv_pkg::*;
#(
  parameter int unsigned LINE_PIXELS  = LinePixelsDef,
  parameter int unsigned SINE_ENTRIES = SineEntriesDef,
  parameter int unsigned PHASE_BITS   = PhaseBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dp_cmd_e                    cmd_i,
  output dp_status_t                 dp_status_o,
  input  logic [OpW-1:0]             opcode_i,
  input  logic [PixIdxW-1:0]         pixel_index_i,
  input  logic [PixValW-1:0]         pixel_value_i,
  input  logic [Freq16W-1:0]         tone_freq_x16_i,
  input  logic [TimeW-1:0]           start_time_us_i,
  input  logic [TimeW-1:0]           end_time_us_i,
  input  logic [LineWidW-1:0]        line_width_i,
  input  logic                       cfg_we_i,
  input  logic [CfgIdxW-1:0]         cfg_index_i,
  input  logic [CfgDataW-1:0]        cfg_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SampleW-1:0]  sample_o,
  output logic [CntW-1:0]            sample_position_o,
  output logic [StatusW-1:0]         status_o
);

  // Derived widths.
  localparam int unsigned AW    = (LINE_PIXELS > 1) ? $clog2(LINE_PIXELS) : 1;
  localparam int unsigned LB    = $clog2(SINE_ENTRIES);
  localparam int unsigned QE    = SINE_ENTRIES / 4;
  localparam int unsigned NowW  = CntW + UsPerSW;
  localparam int unsigned ProdW = TimeW + RateW;
  localparam int unsigned NwW   = NowW + LineWidW;
  localparam int unsigned FqW   = 25;
  localparam int unsigned QW    = FqW + PHASE_BITS - 12;
  localparam int unsigned DW    = ProdW;
  localparam int unsigned RW    = DW + 1;
  localparam int unsigned CW    = $clog2(QW + 1);

  // Quarter-wave sine table, built at elaboration.
  logic [MagW-1:0] quarter_rom [QE];
  for (genvar g = 0; g < QE; g++) begin : g_rom
    localparam logic [MagW-1:0] Mag = sine_mag(g, LB - 2);
    assign quarter_rom[g] = Mag;
  end
  localparam logic [MagW-1:0] TopMag = sine_mag(QE, LB - 2);

  // Configuration and running state.
  logic [RateW-1:0]    rate_q;
  logic [AmpW-1:0]     amp_q;
  logic [15:0]         black_q;
  logic [15:0]         hpl_q;
  logic [CapW-1:0]     cap_q;
  logic [CntW-1:0]     count_q;
  logic [PHASE_BITS-1:0] phase_q;
  logic [CW-1:0]       div_cnt_q;
  logic                out_valid_q;

  // Latched command fields.
  opcode_e             op_q;
  logic [PixIdxW-1:0]  pix_idx_q;
  logic [PixValW-1:0]  pix_val_q;
  logic [Freq16W-1:0]  tone_q;
  logic [TimeW-1:0]    start_q;
  logic [TimeW-1:0]    end_q;
  logic [LineWidW-1:0] lwid_q;

  // Working registers.
  logic [NowW-1:0]     now_q;
  logic [ProdW-1:0]    end_rate_q;
  logic [ProdW-1:0]    start_rate_q;
  logic [ProdW-1:0]    d_q;
  logic [MagW-1:0]     mag_q;
  logic                neg_q;
  logic [SampleW-1:0]  s_q;
  status_e             res_status_q;
  logic [NowW-1:0]     n_q;
  logic                pix_ok_q;
  logic [LineWidW-1:0] width_q;
  logic [FqW-1:0]      freq_q;
  logic [NwW-1:0]      nw_q;
  logic                big_q;
  logic [LineWidW-1:0] idx_q;
  logic [PixValW-1:0]  rdata_q;
  logic [RW-1:0]       div_rem_q;
  logic [QW-1:0]       div_quo_q;
  logic [DW-1:0]       div_den_q;
  logic signed [SampleW-1:0] sample_q;
  logic [CntW-1:0]     pos_q;
  status_e             status_q;

  logic [PixValW-1:0]  line_mem_q [LINE_PIXELS];

  // A zero rate counts as one.
  logic [RateW-1:0] rate_eff;
  assign rate_eff = (rate_q == '0) ? RateW'(1) : rate_q;

  // Sine lookup from the top phase bits.
  logic [LB-1:0]       sidx;
  logic [1:0]          quad;
  logic [LB-2:0]       snum;
  logic [MagW-1:0]     mag_sel;
  always_comb begin
    sidx = phase_q[PHASE_BITS-1 -: LB];
    quad = sidx[LB-1 -: 2];
    snum = quad[0] ? ((LB - 1)'(QE) - {1'b0, sidx[LB-3:0]}) : {1'b0, sidx[LB-3:0]};
    mag_sel = (snum == (LB - 1)'(QE)) ? TopMag : quarter_rom[snum[LB-3:0]];
  end

  // Rounded amplitude scaling.
  logic [AmpW+MagW:0] amp_prod;
  assign amp_prod = (AmpW + MagW + 1)'(amp_q) * (AmpW + MagW + 1)'(mag_q)
                  + (AmpW + MagW + 1)'(16384);

  // Segment end and buffer checks.
  logic done_c;
  logic full_c;
  assign done_c = ProdW'(now_q) >= end_rate_q;
  assign full_c = count_q >= cap_q;

  // Effective line width, clamped to the store.
  logic [LineWidW-1:0] wsel;
  always_comb begin
    wsel = (lwid_q == '0) ? LineWidW'(1) : lwid_q;
    if (32'(wsel) > LINE_PIXELS) begin
      wsel = LineWidW'(LINE_PIXELS);
    end
  end

  // One restoring division step.
  logic [RW-1:0] rem_sh;
  logic          rem_ge;
  assign rem_sh = {div_rem_q[RW-2:0], div_quo_q[QW-1]};
  assign rem_ge = rem_sh >= {1'b0, div_den_q};

  logic [LineWidW-1:0] q_pix;
  assign q_pix = div_quo_q[LineWidW-1:0];

  assign dp_status_o.op       = op_q;
  assign dp_status_o.stop     = done_c || full_c;
  assign dp_status_o.div_done = (div_cnt_q == '0);
  assign dp_status_o.out_busy = out_valid_q && out_stall_i;

  // Control state: configuration, counters, output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q      <= RateRst;
      amp_q       <= AmpRst;
      black_q     <= BlackRst;
      hpl_q       <= StepRst;
      cap_q       <= CapRst;
      count_q     <= '0;
      phase_q     <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      op_q        <= OP_LOAD;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_RATE:  rate_q  <= cfg_data_i[RateW-1:0];
          CFG_AMP:   amp_q   <= cfg_data_i[AmpW-1:0];
          CFG_BLACK: black_q <= cfg_data_i[15:0];
          CFG_STEP:  hpl_q   <= cfg_data_i[15:0];
          CFG_CAP:   cap_q   <= cfg_data_i[CapW-1:0];
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i)
        CMD_LATCH:    op_q <= opcode_e'(opcode_i);
        CMD_RESTART: begin
          count_q <= '0;
          phase_q <= '0;
        end
        CMD_PDIV_LD:  div_cnt_q <= CW'(LineWidW);
        CMD_SDIV_LD:  div_cnt_q <= CW'(QW);
        CMD_DIV_STEP: div_cnt_q <= div_cnt_q - CW'(1);
        CMD_EMIT: begin
          out_valid_q <= 1'b1;
          if (res_status_q == ST_SAMPLE) begin
            count_q <= count_q + CntW'(1);
            phase_q <= phase_q + div_quo_q[PHASE_BITS-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers, divider and line store.
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LATCH: begin
        pix_idx_q <= pixel_index_i;
        pix_val_q <= pixel_value_i;
        tone_q    <= tone_freq_x16_i;
        start_q   <= start_time_us_i;
        end_q     <= end_time_us_i;
        lwid_q    <= line_width_i;
      end
      CMD_LOAD: begin
        if (32'(pix_idx_q) < LINE_PIXELS) begin
          line_mem_q[AW'(pix_idx_q)] <= pix_val_q;
        end
      end
      CMD_MUL_A: begin
        now_q      <= NowW'(count_q) * NowW'(UsPerS);
        end_rate_q <= ProdW'(end_q) * ProdW'(rate_eff);
        mag_q      <= mag_sel;
        neg_q      <= quad[1];
      end
      CMD_MUL_B: begin
        start_rate_q <= ProdW'(start_q) * ProdW'(rate_eff);
        d_q          <= ProdW'(end_q - start_q) * ProdW'(rate_eff);
        s_q          <= amp_prod[AmpW+MagW -: SampleW];
      end
      CMD_CHECK: begin
        res_status_q <= done_c ? ST_DONE : (full_c ? ST_FULL : ST_SAMPLE);
        n_q          <= now_q - start_rate_q[NowW-1:0];
        pix_ok_q     <= (end_q > start_q) && (ProdW'(now_q) > start_rate_q);
        width_q      <= wsel;
        freq_q       <= FqW'({tone_q, 8'b0});
      end
      CMD_NW: begin
        nw_q  <= NwW'(n_q) * NwW'(width_q);
        big_q <= ProdW'(n_q) >= d_q;
      end
      CMD_PDIV_LD: begin
        div_rem_q <= RW'(nw_q[NwW-1:LineWidW]);
        div_quo_q <= {nw_q[LineWidW-1:0], {(QW - LineWidW){1'b0}}};
        div_den_q <= d_q;
      end
      CMD_SDIV_LD: begin
        div_rem_q <= '0;
        div_quo_q <= {freq_q, {(PHASE_BITS - 12){1'b0}}};
        div_den_q <= DW'(rate_eff);
      end
      CMD_DIV_STEP: begin
        div_rem_q <= rem_ge ? (rem_sh - {1'b0, div_den_q}) : rem_sh;
        div_quo_q <= {div_quo_q[QW-2:0], rem_ge};
      end
      CMD_PIX: begin
        if (!pix_ok_q) begin
          idx_q <= '0;
        end else if (big_q || (q_pix >= width_q)) begin
          idx_q <= width_q - LineWidW'(1);
        end else begin
          idx_q <= q_pix;
        end
      end
      CMD_READ: begin
        rdata_q <= line_mem_q[AW'(idx_q)];
      end
      CMD_FREQ: begin
        freq_q <= FqW'({black_q, 8'b0}) + FqW'(rdata_q) * FqW'(hpl_q);
      end
      CMD_EMIT: begin
        pos_q    <= count_q;
        status_q <= res_status_q;
        if (res_status_q == ST_SAMPLE) begin
          sample_q <= neg_q ? -$signed(s_q) : $signed(s_q);
        end else begin
          sample_q <= '0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o       = out_valid_q;
  assign sample_o          = sample_q;
  assign sample_position_o = pos_q;
  assign status_o          = status_q;

endmodule

@@ design/sstv_tone_scan_oscillator.sv @@
// Phase-continuous tone and scan oscillator for slow-scan TV audio.
// Commands enter on the input channel (in_valid_i / in_stall_o); one word is
// taken at an edge with valid high and stall low. A load writes one pixel into
// the line store and a restart clears the sample count and phase; neither
// gives a result. A tone or scan step gives exactly one result word on the
// output channel (out_valid_o / out_stall_i): a sample, segment done or
// buffer full. Registers are written through cfg_valid_i / cfg_ready_o with
// cfg_index_i and cfg_data_i; the user must write them only while no
// command is in flight, as the block itself does not enforce it. A tone
// step runs the bit-serial divider once and a scan step twice: 11 steps for
// the pixel index and 25 + PHASE_BITS - 12 steps for the phase increment.
// A step that ends in done or full skips the divider.
// The result sits in an output register; the next command is accepted while
// it waits, and a later result holds in the controller until the receiver
// releases the stall. Reset restores the default registers and clears count,
// phase and all handshake state; line store contents are not cleared.
module sstv_tone_scan_oscillator
  import sstv_pkg::*;
#(
  parameter int unsigned LINE_PIXELS  = LinePixelsDef,
  parameter int unsigned SINE_ENTRIES = SineEntriesDef,
  parameter int unsigned PHASE_BITS   = PhaseBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [OpW-1:0]            opcode_i,
  input  logic [PixIdxW-1:0]        pixel_index_i,
  input  logic [PixValW-1:0]        pixel_value_i,
  input  logic [Freq16W-1:0]        tone_freq_x16_i,
  input  logic [TimeW-1:0]          start_time_us_i,
  input  logic [TimeW-1:0]          end_time_us_i,
  input  logic [LineWidW-1:0]       line_width_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [CfgDataW-1:0]       cfg_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [SampleW-1:0] sample_o,
  output logic [CntW-1:0]           sample_position_o,
  output logic [StatusW-1:0]        status_o
);

  dp_cmd_e    cmd;
  dp_status_t dp_status;

  // Register writes are always taken.
  assign cfg_ready_o = 1'b1;

  sstv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  sstv_dp #(
    .LINE_PIXELS  (LINE_PIXELS),
    .SINE_ENTRIES (SINE_ENTRIES),
    .PHASE_BITS   (PHASE_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .dp_status_o       (dp_status),
    .opcode_i          (opcode_i),
    .pixel_index_i     (pixel_index_i),
    .pixel_value_i     (pixel_value_i),
    .tone_freq_x16_i   (tone_freq_x16_i),
    .start_time_us_i   (start_time_us_i),
    .end_time_us_i     (end_time_us_i),
    .line_width_i      (line_width_i),
    .cfg_we_i          (cfg_valid_i && cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .sample_o          (sample_o),
    .sample_position_o (sample_position_o),
    .status_o          (status_o)
  );

endmodule

@@ test/sstv_tone_scan_oscillator_test.sv @@
`timescale 1ns / 1ps

module sstv_tone_scan_oscillator_test;
  import sstv_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned DrainCycles = 120;
  localparam int unsigned HoldCycles = 500;
  localparam int unsigned FillPixels = 256;

  // Quarter-wave polynomial coefficients, Q30.
  localparam logic [63:0] PolyA1 = 64'd1686629713;
  localparam logic [63:0] PolyA3 = 64'd693598668;
  localparam logic [63:0] PolyA5 = 64'd85569306;
  localparam logic [63:0] PolyA7 = 64'd5026994;
  localparam logic [63:0] PolyA9 = 64'd172273;

  typedef struct {
    opcode_e     op;
    logic [9:0]  pix_idx;
    logic [7:0]  pix_val;
    logic [15:0] tone;
    logic [31:0] t_start;
    logic [31:0] t_end;
    logic [10:0] width;
  } command_t;

  typedef struct {
    logic signed [15:0] smp;
    logic [24:0]        pos;
    status_e            st;
  } tone_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] opcode = '0;
  logic [9:0] pixel_index = '0;
  logic [7:0] pixel_value = '0;
  logic [15:0] tone_freq = '0;
  logic [31:0] start_time = '0;
  logic [31:0] end_time = '0;
  logic [10:0] line_width = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [24:0] cfg_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] sample;
  logic [24:0] sample_position;
  logic [1:0] status;

  sstv_tone_scan_oscillator dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .opcode_i          (opcode),
    .pixel_index_i     (pixel_index),
    .pixel_value_i     (pixel_value),
    .tone_freq_x16_i   (tone_freq),
    .start_time_us_i   (start_time),
    .end_time_us_i     (end_time),
    .line_width_i      (line_width),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .sample_o          (sample),
    .sample_position_o (sample_position),
    .status_o          (status)
  );

  // Oscillator mirror: registers and state.
  logic [17:0] osc_rate;
  logic [14:0] osc_amp;
  logic [15:0] osc_black;
  logic [15:0] osc_level_step;
  logic [24:0] osc_cap;
  logic [24:0] osc_count;
  logic [31:0] osc_phase;
  logic [7:0]  osc_line [1024];

  command_t     pending_cmds[$];
  tone_result_t expected_results[$];
  command_t     cur_cmd;
  int unsigned  errors = 0;
  int unsigned  cmds_taken = 0;
  int unsigned  n_sample = 0;
  int unsigned  n_done = 0;
  int unsigned  n_full = 0;
  int unsigned  cycles = 0;
  int unsigned  feed_gap = 0;
  int unsigned  stall_left = 0;
  int unsigned  hold_left = 0;
  bit           hold_req = 1'b0;
  bit           calm = 1'b0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Sine magnitude in Q15 of table entry idx (1024 entries), sign through neg.
  function automatic logic [14:0] sine_mag(input logic [9:0] idx, output bit neg);
    logic [63:0] u, u2, t, m;
    logic [7:0]  r;
    r   = idx[7:0];
    u   = idx[8] ? ((64'd256 - r) << 22) : (64'(r) << 22);
    neg = idx[9];
    u2  = (u * u) >> 30;
    t   = PolyA7 - ((u2 * PolyA9) >> 30);
    t   = PolyA5 - ((u2 * t) >> 30);
    t   = PolyA3 - ((u2 * t) >> 30);
    t   = PolyA1 - ((u2 * t) >> 30);
    m   = (((u * t) >> 30) + 64'd16384) >> 15;
    if (m > 64'd32767) m = 64'd32767;
    return m[14:0];
  endfunction

  // Work out the result of one accepted command and advance the mirror.
  task automatic predict_tone(input command_t c);
    logic [63:0] rate, now, lim, freq, width, pidx, n, d, s, mag;
    tone_result_t r;
    bit neg;
    rate = (osc_rate == 0) ? 64'd1 : 64'(osc_rate);
    now = 64'(osc_count) * 64'd1000000;
    lim = 64'(c.t_end) * rate;
    if (c.op == OP_LOAD) begin
      osc_line[c.pix_idx] = c.pix_val;
      return;
    end
    if (c.op == OP_RESTART) begin
      osc_count = '0;
      osc_phase = '0;
      return;
    end
    r.pos = osc_count;
    if (now >= lim || osc_count >= osc_cap) begin
      r.smp = '0;
      r.st = (now >= lim) ? ST_DONE : ST_FULL;
      expected_results.push_back(r);
      return;
    end
    if (c.op == OP_TONE) begin
      freq = 64'(c.tone) << 8;
    end else begin
      width = (c.width == 0) ? 64'd1 : (c.width > 1024) ? 64'd1024 : 64'(c.width);
      pidx = '0;
      if (c.t_end > c.t_start && now > 64'(c.t_start) * rate) begin
        n = now - 64'(c.t_start) * rate;
        d = 64'(c.t_end - c.t_start) * rate;
        pidx = (n * width) / d;
        if (pidx >= width) pidx = width - 64'd1;
      end
      freq = (64'(osc_black) << 8) + 64'(osc_line[pidx[9:0]]) * 64'(osc_level_step);
    end
    mag = 64'(sine_mag(osc_phase[31:22], neg));
    s = (64'(osc_amp) * mag + 64'd16384) >> 15;
    r.smp = neg ? -s[15:0] : s[15:0];
    r.st = ST_SAMPLE;
    expected_results.push_back(r);
    osc_count = osc_count + 25'd1;
    osc_phase = osc_phase + 32'((freq << 20) / rate);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("MISMATCH %s at position %0d: got %0d, expected %0d",
             what, sample_position, got, want);
  endtask

  // Command driver: present one word at a time, predict on acceptance.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        predict_tone(cur_cmd);
        cmds_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (feed_gap > 0) begin
          feed_gap--;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cur_cmd = pending_cmds.pop_front();
          opcode <= cur_cmd.op;
          pixel_index <= cur_cmd.pix_idx;
          pixel_value <= cur_cmd.pix_val;
          tone_freq <= cur_cmd.tone;
          start_time <= cur_cmd.t_start;
          end_time <= cur_cmd.t_end;
          line_width <= cur_cmd.width;
          in_valid <= 1'b1;
          feed_gap = calm ? 0 : gap_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random stalls and an occasional long hold-off.
  always @(posedge clk_i) begin
    tone_result_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected word", status, -1);
        end else begin
          want = expected_results.pop_front();
          if (status != want.st) report_mismatch("status", status, want.st);
          if (sample_position != want.pos)
            report_mismatch("position", sample_position, want.pos);
          if (sample !== want.smp) report_mismatch("sample", sample, want.smp);
          case (want.st)
            ST_SAMPLE: n_sample++;
            ST_DONE:   n_done++;
            default:   n_full++;
          endcase
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = calm ? 0 : gap_len();
      end
    end
  end

  function automatic command_t make_cmd(input opcode_e op, input logic [15:0] tone,
                                        input logic [31:0] t_start, input logic [31:0] t_end,
                                        input logic [10:0] width);
    command_t c;
    c.op = op;
    c.pix_idx = 10'($urandom);
    c.pix_val = 8'($urandom);
    c.tone = tone;
    c.t_start = t_start;
    c.t_end = t_end;
    c.width = width;
    return c;
  endfunction

  // Random widths stay within the filled part of the line store.
  function automatic command_t random_cmd();
    command_t c;
    int unsigned r;
    r = $urandom_range(0, 99);
    c = make_cmd(r < 40 ? OP_TONE : r < 75 ? OP_SCAN : r < 90 ? OP_LOAD : OP_RESTART,
                 16'($urandom), 0, 0, 0);
    r = $urandom_range(0, 9);
    c.t_end = (r < 5) ? $urandom : (r < 8) ? $urandom_range(0, 50000) : $urandom_range(0, 2000);
    r = $urandom_range(0, 3);
    c.t_start = (r < 2) ? $urandom_range(0, 20000) : (r == 2) ? $urandom : 0;
    r = $urandom_range(0, 9);
    c.width = (r < 9) ? 11'($urandom_range(1, FillPixels)) : 11'd0;
    return c;
  endfunction

  task automatic wait_idle();
    while (pending_cmds.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Register writes: valid stays high across back-to-back words.
  task automatic write_regs(input logic [24:0] rate, input logic [24:0] amp,
                            input logic [24:0] black, input logic [24:0] lstep,
                            input logic [24:0] cap);
    logic [24:0] vals [5];
    vals = '{rate, amp, black, lstep, cap};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data <= vals[i];
      do @(posedge clk_i); while (!cfg_ready);
      case (cfg_reg_e'(i))
        CFG_RATE:  osc_rate = vals[i][17:0];
        CFG_AMP:   osc_amp = vals[i][14:0];
        CFG_BLACK: osc_black = vals[i][15:0];
        CFG_STEP:  osc_level_step = vals[i][15:0];
        default:   osc_cap = vals[i];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int unsigned count);
    for (int i = 0; i < count; i++) pending_cmds.push_back(random_cmd());
    wait_idle();
  endtask

  initial begin
    command_t c;
    osc_rate = RateRst;
    osc_amp = AmpRst;
    osc_black = BlackRst;
    osc_level_step = StepRst;
    osc_cap = CapRst;
    osc_count = '0;
    osc_phase = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the part of the line store that scans can reach.
    calm = 1'b1;
    for (int i = 0; i < FillPixels; i++) begin
      c = make_cmd(OP_LOAD, 0, 0, 0, 0);
      c.pix_idx = 10'(i);
      if (i < 2) c.pix_val = i ? 8'd255 : 8'd0;
      pending_cmds.push_back(c);
    end
    wait_idle();
    calm = 1'b0;

    // Directed commands at the reset settings.
    pending_cmds.push_back(make_cmd(OP_TONE, 16'd0, 0, '1, 0));
    pending_cmds.push_back(make_cmd(OP_TONE, 16'hFFFF, 0, '1, 0));
    pending_cmds.push_back(make_cmd(OP_TONE, 16'd16000, 0, '1, 0));
    pending_cmds.push_back(make_cmd(OP_TONE, 16'd16000, 0, '1, 0));
    pending_cmds.push_back(make_cmd(OP_SCAN, 0, 0, '1, 11'd1024));
    pending_cmds.push_back(make_cmd(OP_SCAN, 0, 32'd500, 32'd100, 11'd64));
    pending_cmds.push_back(make_cmd(OP_SCAN, 0, '1, '1, 11'd0));
    pending_cmds.push_back(make_cmd(OP_SCAN, 0, 0, 32'd1000, 11'd2047));
    pending_cmds.push_back(make_cmd(OP_SCAN, 0, 0, 32'd200, 11'd1));
    pending_cmds.push_back(make_cmd(OP_TONE, 16'd8000, 0, 32'd0, 0));
    pending_cmds.push_back(make_cmd(OP_SCAN, 0, 0, 32'd1, 11'd10));
    c = make_cmd(OP_LOAD, 0, 0, 0, 0);
    c.pix_idx = 10'd1023;
    c.pix_val = 8'd255;
    pending_cmds.push_back(c);
    pending_cmds.push_back(make_cmd(OP_SCAN, 0, 0, '1, 11'd1024));
    pending_cmds.push_back(make_cmd(OP_RESTART, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_TONE, 16'd24000, 0, '1, 0));
    wait_idle();

    // Register settings, extremes among them.
    write_regs(25'd8000, 25'd32767, 25'd0, 25'd65535, 25'h1FFFFFF);
    run_random(40);
    write_regs(25'd0, 25'd0, 25'd65535, 25'd0, 25'd5);
    run_random(40);
    write_regs(25'd262143, 25'd1, 25'd1234, 25'd777, 25'd0);
    run_random(20);
    write_regs(25'd192000, 25'd16384, 25'd24000, 25'd12850, 25'd40);
    for (int i = 5; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data <= 25'($urandom);
      do @(posedge clk_i); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    run_random(40);
    write_regs(25'd1, 25'd32767, 25'd40000, 25'd30000, 25'd16777216);
    run_random(40);

    // Receiver holds off while the sender keeps offering words.
    write_regs(25'd44100, 25'd20000, 25'd24000, 25'd12850, 25'd16777216);
    calm = 1'b1;
    hold_req = 1'b1;
    run_random(40);
    calm = 1'b0;
    run_random(60);

    wait_idle();
    $display("Commands accepted: %0d; results: %0d samples, %0d done, %0d full.",
             cmds_taken, n_sample, n_done, n_full);
    $display("Six register settings, a long output hold-off and idle gaps on both sides.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/sstv_pkg.sv
design/sstv_ctrl.sv
design/sstv_dp.sv
design/sstv_tone_scan_oscillator.sv
test/sstv_tone_scan_oscillator_test.sv
